### src/assert_macros.svh
// assertion helpers used by delimiter_balance_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

### src/dbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dbc_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 7;
  localparam int CHAR_W      = 8;

  // characters of interest
  localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_LSQ    = 8'h5B;
  localparam logic [CHAR_W-1:0] CHAR_RSQ    = 8'h5D;
  localparam logic [CHAR_W-1:0] CHAR_LCURLY = 8'h7B;
  localparam logic [CHAR_W-1:0] CHAR_RCURLY = 8'h7D;
  localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;

  // stack entry codes
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PAREN   = 3'd1,
    KIND_SQUARE  = 3'd2,
    KIND_CURLY   = 3'd3,
    KIND_COMMENT = 3'd4,
    KIND_FAIL    = 3'd5
  } kind_t;

  // classified operation
  typedef enum logic [2:0] {
    OP_OTHER,
    OP_CLEAR,
    OP_END,
    OP_OPEN,
    OP_CLOSE,
    OP_SLASH,
    OP_STAR
  } op_t;

  // one queued transaction between front and back
  typedef struct packed {
    op_t   op;
    kind_t kind;
  } entry_t;

endpackage

`default_nettype wire

### src/dbc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dbc_front (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [dbc_pkg::CHAR_W-1:0] character,
  input  wire logic                       clear_stack,
  input  wire logic                       q_full,
  output logic                            q_wr,
  output dbc_pkg::entry_t                 q_data
);

  // a transaction enters the queue whenever there is room
  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  // character decoder
  always_comb begin
    q_data.op   = dbc_pkg::OP_OTHER;
    q_data.kind = dbc_pkg::KIND_NONE;
    if (clear_stack) begin
      q_data.op = dbc_pkg::OP_CLEAR;
    end else begin
      unique case (character)
        dbc_pkg::CHAR_SEMI: begin
          q_data.op = dbc_pkg::OP_END;
        end
        dbc_pkg::CHAR_LPAREN: begin
          q_data.op   = dbc_pkg::OP_OPEN;
          q_data.kind = dbc_pkg::KIND_PAREN;
        end
        dbc_pkg::CHAR_LSQ: begin
          q_data.op   = dbc_pkg::OP_OPEN;
          q_data.kind = dbc_pkg::KIND_SQUARE;
        end
        dbc_pkg::CHAR_LCURLY: begin
          q_data.op   = dbc_pkg::OP_OPEN;
          q_data.kind = dbc_pkg::KIND_CURLY;
        end
        dbc_pkg::CHAR_RPAREN: begin
          q_data.op   = dbc_pkg::OP_CLOSE;
          q_data.kind = dbc_pkg::KIND_PAREN;
        end
        dbc_pkg::CHAR_RSQ: begin
          q_data.op   = dbc_pkg::OP_CLOSE;
          q_data.kind = dbc_pkg::KIND_SQUARE;
        end
        dbc_pkg::CHAR_RCURLY: begin
          q_data.op   = dbc_pkg::OP_CLOSE;
          q_data.kind = dbc_pkg::KIND_CURLY;
        end
        dbc_pkg::CHAR_SLASH: begin
          q_data.op   = dbc_pkg::OP_SLASH;
          q_data.kind = dbc_pkg::KIND_COMMENT;
        end
        dbc_pkg::CHAR_STAR: begin
          q_data.op   = dbc_pkg::OP_STAR;
          q_data.kind = dbc_pkg::KIND_COMMENT;
        end
        default: begin
          q_data.op = dbc_pkg::OP_OTHER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/dbc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dbc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire dbc_pkg::entry_t wr_data,
  output logic                 full,
  output logic                 rd_valid,
  input  wire logic            rd,
  output dbc_pkg::entry_t      rd_data
);

  dbc_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/dbc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dbc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire dbc_pkg::entry_t             q_data,
  output logic                             q_rd,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             stack_empty,
  output logic [dbc_pkg::DEPTH_W-1:0]      depth,
  output logic                             mismatch_now,
  output logic                             halted
);

  localparam logic [dbc_pkg::CNT_W-1:0] CNT_ONE  = dbc_pkg::CNT_W'(1);
  localparam logic [dbc_pkg::CNT_W-1:0] CNT_TWO  = dbc_pkg::CNT_W'(2);
  localparam logic [dbc_pkg::CNT_W-1:0] CNT_FULL = dbc_pkg::CNT_W'(dbc_pkg::STACK_DEPTH);

  // stack: top and the entry below it in registers, all lower entries in memory
  dbc_pkg::kind_t mem [dbc_pkg::STACK_DEPTH];
  dbc_pkg::kind_t top;
  dbc_pkg::kind_t below;
  logic [dbc_pkg::CNT_W-1:0] count;
  logic prev_slash;
  logic prev_star;
  logic halted_flag;

  dbc_pkg::kind_t            top_next;
  logic [dbc_pkg::CNT_W-1:0] count_next;
  logic                      prev_slash_next;
  logic                      prev_star_next;
  logic                      halted_next;
  logic                      mismatch;
  logic                      push;
  logic                      pop;
  dbc_pkg::kind_t            push_kind;
  logic                      wr_en;
  logic [dbc_pkg::PTR_W-1:0] wr_addr;
  logic [dbc_pkg::PTR_W-1:0] rd_addr;
  logic                      is_open;
  logic                      is_close;
  logic                      fire;

  // take a queued transaction when the output register is free
  assign fire = q_valid && (!out_valid || !out_stall);
  assign q_rd = fire;

  // operation decode against the pair memory
  always_comb begin
    prev_slash_next = prev_slash;
    prev_star_next  = prev_star;
    halted_next     = halted_flag;
    mismatch        = 1'b0;
    is_open         = 1'b0;
    is_close        = 1'b0;
    if (q_data.op == dbc_pkg::OP_CLEAR) begin
      prev_slash_next = 1'b0;
      prev_star_next  = 1'b0;
      halted_next     = 1'b0;
    end else if (q_data.op == dbc_pkg::OP_END) begin
      prev_slash_next = 1'b0;
      prev_star_next  = 1'b0;
      halted_next     = 1'b0;
    end else if (!halted_flag) begin
      prev_slash_next = (q_data.op == dbc_pkg::OP_SLASH);
      prev_star_next  = (q_data.op == dbc_pkg::OP_STAR);
      unique case (q_data.op)
        dbc_pkg::OP_OPEN:  is_open  = 1'b1;
        dbc_pkg::OP_CLOSE: is_close = 1'b1;
        dbc_pkg::OP_STAR:  is_open  = prev_slash;
        dbc_pkg::OP_SLASH: is_close = prev_star;
        default: begin
          is_open  = 1'b0;
          is_close = 1'b0;
        end
      endcase
      // opener on a full stack halts without a push
      if (is_open && (count == CNT_FULL)) begin
        mismatch    = 1'b1;
        halted_next = 1'b1;
      end
      // closer on an empty stack or a wrong top
      if (is_close && ((count == '0) || (top != q_data.kind))) begin
        mismatch    = 1'b1;
        halted_next = 1'b1;
      end
      if (halted_next) begin
        prev_slash_next = 1'b0;
        prev_star_next  = 1'b0;
      end
    end
  end

  // stack moves
  always_comb begin
    push       = 1'b0;
    pop        = 1'b0;
    push_kind  = q_data.kind;
    top_next   = top;
    count_next = count;
    if (is_open && !mismatch) begin
      push = 1'b1;
    end else if (is_close && mismatch && (count != CNT_FULL)) begin
      push      = 1'b1;
      push_kind = dbc_pkg::KIND_FAIL;
    end else if (is_close && !mismatch) begin
      pop = 1'b1;
    end
    if (q_data.op == dbc_pkg::OP_CLEAR) begin
      count_next = '0;
    end else begin
      if (push) begin
        count_next = count + CNT_ONE;
        top_next   = push_kind;
      end else if (pop) begin
        count_next = count - CNT_ONE;
        top_next   = below;
      end
    end
  end

  assign wr_en   = fire && push && (count != '0);
  assign wr_addr = dbc_pkg::PTR_W'(count - CNT_ONE);
  assign rd_addr = dbc_pkg::PTR_W'(count_next - CNT_TWO);

  // memory of the lower entries, with the entry below the top read ahead
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    if (fire) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        below <= top;
      end else begin
        below <= mem[rd_addr];
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      prev_slash  <= 1'b0;
      prev_star   <= 1'b0;
      halted_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        count       <= count_next;
        prev_slash  <= prev_slash_next;
        prev_star   <= prev_star_next;
        halted_flag <= halted_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fire) begin
      top          <= top_next;
      stack_empty  <= (count_next == '0);
      depth        <= dbc_pkg::DEPTH_W'(count_next);
      mismatch_now <= mismatch;
      halted       <= halted_next;
    end
  end

endmodule

`default_nettype wire

### src/delimiter_balance_checker.sv
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// input    | in_valid, in_stall  | character[7:0], clear_stack
// output   | out_valid, out_stall| stack_empty, depth[6:0], mismatch_now, halted
//
// one transaction per clock while out_stall is low; a character costs at most
// one stack push or pop; decode into a two-slot queue, then stack update into
// the output register; the entry below the top is read ahead from stack memory
// reset (rst, synchronous) empties the stack and clears halt and pair memory;
// the stack memory itself is not cleared
// an output stall holds the result; the queue then fills and raises in_stall
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module delimiter_balance_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 character,
  input  wire logic                       clear_stack,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            stack_empty,
  output logic [dbc_pkg::DEPTH_W-1:0]     depth,
  output logic                            mismatch_now,
  output logic                            halted
);

  logic            q_full;
  logic            q_wr;
  dbc_pkg::entry_t q_wr_data;
  logic            q_valid;
  logic            q_rd;
  dbc_pkg::entry_t q_rd_data;

  // decode front
  dbc_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .character   (character),
    .clear_stack (clear_stack),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wr_data)
  );

  // decoupling queue
  dbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd       (q_rd),
    .rd_data  (q_rd_data)
  );

  // stack back end
  dbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_rd_data),
    .q_rd         (q_rd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stack_empty  (stack_empty),
    .depth        (depth),
    .mismatch_now (mismatch_now),
    .halted       (halted)
  );

  // checks
  `ASSERT_CLK_RST(a_mismatch_halts, clk, rst, out_valid && mismatch_now |-> halted, "no halt")
  `ASSERT_CLK_RST(a_empty_depth, clk, rst, out_valid && stack_empty |-> depth == '0, "empty depth")
  `ASSERT_CLK(a_reset_idle, clk, $past(rst) |-> (!out_valid && !in_stall), "busy after reset")

endmodule

`default_nettype wire
